FILE: hw/rtl/mcs_pkg.sv
// shared types and constants for the midi clock sync engine
`timescale 1ns / 1ps

package mcs_pkg;

    // sync modes
    localparam logic [1:0] MODE_SLAVE  = 2'd0;
    localparam logic [1:0] MODE_MASTER = 2'd1;
    localparam logic [1:0] MODE_TAP    = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SYNC_MODE  = 2'd0;
    localparam logic [1:0] CFG_LISTEN_CHN = 2'd1;

    // usb-midi code indexes
    localparam logic [3:0] CIN_REALTIME = 4'h0F;
    localparam logic [3:0] CIN_SYSCOM1  = 4'h05;
    localparam logic [3:0] CIN_NOTE_ON  = 4'h09;
    localparam logic [3:0] CIN_NOTE_OFF = 4'h08;

    // midi bytes
    localparam logic [7:0] MIDI_CLOCK    = 8'hF8;
    localparam logic [7:0] MIDI_START    = 8'hFA;
    localparam logic [7:0] MIDI_CONTINUE = 8'hFB;
    localparam logic [7:0] MIDI_STOP     = 8'hFC;
    localparam logic [7:0] MIDI_NOTE_ON  = 8'h90;
    localparam logic [7:0] VEL_FULL      = 8'h7F;

    // controlling note numbers
    localparam logic [7:0] NOTE_RUN    = 8'd48;
    localparam logic [7:0] NOTE_STOP   = 8'd49;
    localparam logic [7:0] NOTE_DIV_1  = 8'd50;
    localparam logic [7:0] NOTE_DIV_2  = 8'd51;
    localparam logic [7:0] NOTE_DIV_4  = 8'd52;
    localparam logic [7:0] NOTE_DIV_8  = 8'd53;

    localparam logic [3:0] RATIO_RESET = 4'd1;

    typedef enum logic [2:0] {
        OP_MIDI      = 3'd0,
        OP_MASTER    = 3'd1,
        OP_TAP       = 3'd2,
        OP_WATCHDOG  = 3'd3,
        OP_HOST_RUN  = 3'd4,
        OP_HOST_STOP = 3'd5
    } op_t;

    // which packets a processed item sends
    typedef enum logic [1:0] {
        PK_NONE  = 2'd0,
        PK_STOP  = 2'd1,
        PK_CLOCK = 2'd2,
        PK_START = 2'd3   // note-on, start, clock
    } pkt_kind_t;

    // everything the result stage needs to play out one item
    typedef struct packed {
        pkt_kind_t  kind;
        logic [7:0] row;
        logic [3:0] chn;
        logic       pulse;
        logic       run;
        logic [3:0] ratio;
    } mcs_desc_t;

endpackage

FILE: hw/rtl/mcs_step.sv
// next-state and packet selection for one input item
`timescale 1ns / 1ps

module mcs_step import mcs_pkg::*; (
    input  logic [2:0]  operation,
    input  logic [7:0]  packet_header,
    input  logic [7:0]  status_byte,
    input  logic [7:0]  data_one,
    input  logic [7:0]  data_two,
    input  logic [7:0]  master_row,
    input  logic [1:0]  sync_mode,
    input  logic [3:0]  listen_channel,
    input  logic        run_cur,
    input  logic [3:0]  ratio_cur,
    input  logic [3:0]  count_cur,
    output logic        run_next,
    output logic [3:0]  ratio_next,
    output logic [3:0]  count_next,
    output mcs_desc_t   desc
);

    logic [3:0] cin;
    logic [3:0] count_inc;
    logic       hit;
    logic [3:0] count_div;
    logic       pulse;
    pkt_kind_t  kind;

    assign cin       = packet_header[3:0];
    assign count_inc = count_cur + 4'd1;
    assign hit       = (count_inc >= ratio_cur);
    assign count_div = hit ? 4'd0 : count_inc;

    always_comb begin
        run_next   = run_cur;
        ratio_next = ratio_cur;
        count_next = count_cur;
        pulse      = 1'b0;
        kind       = PK_NONE;
        case (op_t'(operation))
            OP_MIDI: begin
                if (cin == CIN_REALTIME || cin == CIN_SYSCOM1) begin
                    if (status_byte == MIDI_CLOCK && sync_mode == MODE_SLAVE && run_cur) begin
                        count_next = count_div;
                        pulse      = hit;
                    end else if (status_byte == MIDI_START || status_byte == MIDI_CONTINUE) begin
                        if (sync_mode == MODE_SLAVE) run_next = 1'b1;
                    end else if (status_byte == MIDI_STOP) begin
                        if (sync_mode == MODE_SLAVE) run_next = 1'b0;
                    end
                end else if ((cin == CIN_NOTE_ON || cin == CIN_NOTE_OFF)
                             && status_byte[3:0] == listen_channel) begin
                    // only a real note-on acts; any note number clears the counter
                    if (cin == CIN_NOTE_ON && data_two != 8'd0) begin
                        if (data_one == NOTE_RUN)        run_next   = 1'b1;
                        else if (data_one == NOTE_STOP)  run_next   = 1'b0;
                        else if (data_one == NOTE_DIV_1) ratio_next = 4'd1;
                        else if (data_one == NOTE_DIV_2) ratio_next = 4'd2;
                        else if (data_one == NOTE_DIV_4) ratio_next = 4'd4;
                        else if (data_one == NOTE_DIV_8) ratio_next = 4'd8;
                        count_next = 4'd0;
                    end
                end
            end
            OP_MASTER: begin
                if (sync_mode == MODE_MASTER) begin
                    if (!run_cur) begin
                        run_next = 1'b1;
                        kind     = PK_START;
                    end else begin
                        kind     = PK_CLOCK;
                    end
                end
            end
            OP_TAP: begin
                if (sync_mode == MODE_TAP && run_cur) begin
                    count_next = count_div;
                    pulse      = hit;
                end
            end
            OP_WATCHDOG: begin
                if (sync_mode == MODE_MASTER && run_cur) begin
                    run_next = 1'b0;
                    kind     = PK_STOP;
                end
            end
            OP_HOST_RUN: begin
                run_next = 1'b1;
            end
            OP_HOST_STOP: begin
                run_next   = 1'b0;
                count_next = 4'd0;
                if (sync_mode == MODE_MASTER) kind = PK_STOP;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        desc.kind  = kind;
        desc.row   = master_row;
        desc.chn   = listen_channel;
        desc.pulse = pulse;
        desc.run   = run_next;
        desc.ratio = ratio_next;
    end

endmodule

FILE: hw/rtl/mcs_result.sv
// result register that plays out one to three results per item
`timescale 1ns / 1ps

module mcs_result import mcs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  mcs_desc_t   desc_in,
    output logic        can_load,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_clock_pulse,
    output logic        m_send_valid,
    output logic [3:0]  m_send_cin,
    output logic [7:0]  m_send_byte_zero,
    output logic [7:0]  m_send_byte_one,
    output logic [7:0]  m_send_byte_two,
    output logic        m_running,
    output logic [3:0]  m_ratio_now,
    output logic        m_last
);

    mcs_desc_t  desc_reg;
    logic       valid_reg;
    logic       valid_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       is_last;
    logic       taken;

    assign is_last  = (desc_reg.kind != PK_START) || (idx_reg == 2'd2);
    assign taken    = valid_reg && m_ready;
    assign can_load = !valid_reg || (taken && is_last);

    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end else if (taken) begin
            if (is_last) valid_next = 1'b0;
            else         idx_next   = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) desc_reg <= desc_in;
    end

    always_comb begin
        m_send_valid     = 1'b0;
        m_send_cin       = 4'd0;
        m_send_byte_zero = 8'd0;
        m_send_byte_one  = 8'd0;
        m_send_byte_two  = 8'd0;
        case (desc_reg.kind)
            PK_STOP: begin
                m_send_valid     = 1'b1;
                m_send_cin       = CIN_REALTIME;
                m_send_byte_zero = MIDI_STOP;
            end
            PK_CLOCK: begin
                m_send_valid     = 1'b1;
                m_send_cin       = CIN_REALTIME;
                m_send_byte_zero = MIDI_CLOCK;
            end
            PK_START: begin
                m_send_valid = 1'b1;
                if (idx_reg == 2'd0) begin
                    m_send_cin       = CIN_NOTE_ON;
                    m_send_byte_zero = MIDI_NOTE_ON | {4'd0, desc_reg.chn};
                    m_send_byte_one  = desc_reg.row;
                    m_send_byte_two  = VEL_FULL;
                end else if (idx_reg == 2'd1) begin
                    m_send_cin       = CIN_REALTIME;
                    m_send_byte_zero = MIDI_START;
                end else begin
                    m_send_cin       = CIN_REALTIME;
                    m_send_byte_zero = MIDI_CLOCK;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid       = valid_reg;
    assign m_clock_pulse = desc_reg.pulse && (idx_reg == 2'd0);
    assign m_running     = desc_reg.run;
    assign m_ratio_now   = desc_reg.ratio;
    assign m_last        = is_last;

endmodule

FILE: hw/rtl/midi_clock_sync_engine_core.sv
// top level of the midi clock sync engine
`timescale 1ns / 1ps

// Clock sync engine for slave, master and tap modes. Each transaction on the
// s_ channel is held in an input register, then decoded against the run
// flag, divide ratio and divide counter and written into the result
// register. Items that give one result flow at one per clock while m_ready
// holds high; a master byte that starts the transport gives three
// results (note-on, start, clock) and occupies the result register until
// all three m_ transactions are taken. Configuration (sync_mode at index 0,
// listen_channel at index 1) is accepted every cycle and should only be
// written while the engine is idle.

module midi_clock_sync_engine_core import mcs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data,
    // input items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [7:0]  s_packet_header,
    input  logic [7:0]  s_status_byte,
    input  logic [7:0]  s_data_one,
    input  logic [7:0]  s_data_two,
    input  logic [7:0]  s_master_row,
    // results
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_clock_pulse,
    output logic        m_send_valid,
    output logic [3:0]  m_send_cin,
    output logic [7:0]  m_send_byte_zero,
    output logic [7:0]  m_send_byte_one,
    output logic [7:0]  m_send_byte_two,
    output logic        m_running,
    output logic [3:0]  m_ratio_now,
    output logic        m_last
);

    logic [1:0] sync_mode_reg;
    logic [3:0] listen_chn_reg;

    logic       in_valid_reg;
    logic [2:0] op_reg;
    logic [7:0] header_reg;
    logic [7:0] status_reg;
    logic [7:0] data_one_reg;
    logic [7:0] data_two_reg;
    logic [7:0] row_reg;

    logic       run_reg;
    logic       run_next;
    logic [3:0] ratio_reg;
    logic [3:0] ratio_next;
    logic [3:0] count_reg;
    logic [3:0] count_next;

    logic       can_load;
    logic       advance;
    mcs_desc_t  desc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_mode_reg  <= MODE_SLAVE;
            listen_chn_reg <= 4'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SYNC_MODE:  sync_mode_reg  <= cfg_data[1:0];
                CFG_LISTEN_CHN: listen_chn_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // item leaves the input register when the result register frees up
    assign advance = in_valid_reg && can_load;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg       <= s_operation;
            header_reg   <= s_packet_header;
            status_reg   <= s_status_byte;
            data_one_reg <= s_data_one;
            data_two_reg <= s_data_two;
            row_reg      <= s_master_row;
        end
    end

    mcs_step u_step (
        .operation      (op_reg),
        .packet_header  (header_reg),
        .status_byte    (status_reg),
        .data_one       (data_one_reg),
        .data_two       (data_two_reg),
        .master_row     (row_reg),
        .sync_mode      (sync_mode_reg),
        .listen_channel (listen_chn_reg),
        .run_cur        (run_reg),
        .ratio_cur      (ratio_reg),
        .count_cur      (count_reg),
        .run_next       (run_next),
        .ratio_next     (ratio_next),
        .count_next     (count_next),
        .desc           (desc)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg   <= 1'b0;
            ratio_reg <= RATIO_RESET;
            count_reg <= 4'd0;
        end else if (advance) begin
            run_reg   <= run_next;
            ratio_reg <= ratio_next;
            count_reg <= count_next;
        end
    end

    mcs_result u_result (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .load             (advance),
        .desc_in          (desc),
        .can_load         (can_load),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_clock_pulse    (m_clock_pulse),
        .m_send_valid     (m_send_valid),
        .m_send_cin       (m_send_cin),
        .m_send_byte_zero (m_send_byte_zero),
        .m_send_byte_one  (m_send_byte_one),
        .m_send_byte_two  (m_send_byte_two),
        .m_running        (m_running),
        .m_ratio_now      (m_ratio_now),
        .m_last           (m_last)
    );

endmodule

FILE: hw/rtl/mcs_checker.sv
// port-level checks for the midi clock sync engine, bound to the top level
`timescale 1ns / 1ps

module mcs_checker import mcs_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_clock_pulse,
    input logic       m_send_valid,
    input logic [3:0] m_send_cin,
    input logic [7:0] m_send_byte_zero,
    input logic [7:0] m_send_byte_one,
    input logic [7:0] m_send_byte_two,
    input logic [3:0] m_ratio_now,
    input logic       m_last
);

    // stalled result holds its packet
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_send_byte_zero) && $stable(m_last))
        else $error("result changed while stalled");

    // empty results carry zero packet fields
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_send_valid |-> m_send_cin == 4'd0 && m_send_byte_zero == 8'd0
            && m_send_byte_one == 8'd0 && m_send_byte_two == 8'd0)
        else $error("empty result with packet data");

    // a divided clock pulse never comes with a packet
    a_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_clock_pulse |-> !m_send_valid && m_last)
        else $error("pulse on a packet result");

    a_ratio: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_ratio_now == 4'd1 || m_ratio_now == 4'd2
            || m_ratio_now == 4'd4 || m_ratio_now == 4'd8)
        else $error("bad divide ratio");

    // a sent note-on is always followed by start and clock of the same item
    a_noteon: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_send_valid && m_send_cin == CIN_NOTE_ON |-> !m_last)
        else $error("note-on marked last");

endmodule

bind midi_clock_sync_engine_core mcs_checker u_mcs_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_clock_pulse    (m_clock_pulse),
    .m_send_valid     (m_send_valid),
    .m_send_cin       (m_send_cin),
    .m_send_byte_zero (m_send_byte_zero),
    .m_send_byte_one  (m_send_byte_one),
    .m_send_byte_two  (m_send_byte_two),
    .m_ratio_now      (m_ratio_now),
    .m_last           (m_last)
);
